@@ src/set_assoc_lru_cache_lookup_unit_assert.svh @@
// Assertion macros shared by the cache lookup RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_UNIT_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SALCL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cache lookup check failed");

// The consequent must hold in the cycle after the antecedent.
`define SALCL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cache lookup check failed");

`endif

@@ src/salcl_pkg.sv @@
package salcl_pkg;

	// Address and counter widths are fixed by the interface.
	localparam int ADDR_W      = 32;
	localparam int CNT_W       = 32;
	// Byte offset inside a 32-bit word.
	localparam int WORD_OFF    = 2;
	// The smallest offset leaves 30 address bits for set index and tag.
	localparam int TAG_W       = ADDR_W - WORD_OFF;
	// Result: hit, access count, hit count, miss count, padded to bytes.
	localparam int OUT_FIELDS_W = 1 + 3 * CNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INDEX_BITS  = 2'd0,
		CFG_BLOCK_LOG2  = 2'd1,
		CFG_WAYS_IN_USE = 2'd2
	} cfg_reg_t;

endpackage

@@ src/set_assoc_lru_cache_lookup_unit.sv @@
// An accepted request is held in the lookup stage, then in the result register.
// Throughput: one request per cycle while results are taken; the set row is read at
// the accept edge and written back as the request leaves the lookup stage, with a
// bypass row for back-to-back requests. Reset: counters clear at once; then a pass
// over the 2**MAX_INDEX_BITS sets (1024 by default) zeroes the valid and recency
// rows, with s_axis_tready held low. Configuration writes are taken during the pass.
`include "set_assoc_lru_cache_lookup_unit_assert.svh"

module set_assoc_lru_cache_lookup_unit #(
	parameter int MAX_INDEX_BITS = 10,
	parameter int NUM_WAYS       = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Request stream. tdata: address [31:0].
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [salcl_pkg::ADDR_W-1:0]       s_axis_tdata,
	// Result stream. tdata: hit [0], access_count [32:1], hit_count [64:33],
	// miss_count [96:65], zero padding [103:97].
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [salcl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// Configuration writes: index 0 index_bits, 1 block_words_log2,
	// 2 ways_in_use.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [salcl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [salcl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import salcl_pkg::*;

	localparam int SETS     = 1 << MAX_INDEX_BITS;
	localparam int RANK_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int WAY_IW   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int META_W   = NUM_WAYS * (1 + RANK_W);
	localparam int TROW_W   = NUM_WAYS * TAG_W;
	localparam int IB_RESET = (MAX_INDEX_BITS < 10) ? MAX_INDEX_BITS : 10;
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_WAYS - 1);

	// Configuration, stored already saturated to the effective values.
	logic [3:0] ib_q;
	logic [1:0] eb_q;
	logic [2:0] ways_q;

	// Clearing pass state.
	logic                      clear_done_q;
	logic [MAX_INDEX_BITS-1:0] clr_idx_q;

	// Lookup stage: the accepted request while its set row is read out.
	logic                      s1_valid_q;
	logic [ADDR_W-1:0]         addr_s1;
	logic [MAX_INDEX_BITS-1:0] set_s1;
	logic                      byp_sel_s1;
	logic [TROW_W-1:0]         byp_tag_s1;
	logic [META_W-1:0]         byp_meta_s1;

	// Result register and running counters.
	logic             out_valid_q;
	logic             out_hit_q;
	logic [CNT_W-1:0] acc_cnt_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;

	logic in_fire;
	logic s1_fire;

	// Set index of the incoming request.
	logic [5:0]                off_in;
	logic [ADDR_W-1:0]         set_full_in;
	logic [MAX_INDEX_BITS-1:0] rd_set;

	// RAM interfaces.
	logic [TROW_W-1:0]         tag_rd;
	logic [META_W-1:0]         meta_rd;
	logic                      meta_we;
	logic [MAX_INDEX_BITS-1:0] meta_waddr;
	logic [META_W-1:0]         meta_wdata;

	// Lookup logic.
	logic [NUM_WAYS-1:0][TAG_W-1:0]  tags_cur;
	logic [NUM_WAYS-1:0]             valid_cur;
	logic [NUM_WAYS-1:0][RANK_W-1:0] rank_cur;
	logic [TAG_W-1:0]                tag_s1c;
	logic                            found;
	logic [NUM_WAYS-1:0]             tgt_oh;
	logic [NUM_WAYS-1:0][TAG_W-1:0]  tags_new;
	logic [NUM_WAYS-1:0]             valid_new;
	logic [NUM_WAYS-1:0][RANK_W-1:0] rank_new;
	logic [TROW_W-1:0]               tag_row_new;
	logic [META_W-1:0]               meta_row_new;

	// Handshakes. The lookup stage moves on when the result register is free
	// or being emptied, so a waiting result that is not taken holds back the next request.
	assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = clear_done_q && (!s1_valid_q || s1_fire);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Configuration registers. Out-of-range values are clamped on the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ib_q   <= 4'(IB_RESET);
			eb_q   <= 2'd0;
			ways_q <= 3'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INDEX_BITS: begin
					if (int'(cfg_data) > MAX_INDEX_BITS) begin
						ib_q <= 4'(MAX_INDEX_BITS);
					end else begin
						ib_q <= cfg_data;
					end
				end
				CFG_BLOCK_LOG2: begin
					eb_q <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
				end
				CFG_WAYS_IN_USE: begin
					if (cfg_data[2:0] == 3'd0) begin
						ways_q <= 3'd1;
					end else if (int'(cfg_data[2:0]) > NUM_WAYS) begin
						ways_q <= 3'(NUM_WAYS);
					end else begin
						ways_q <= cfg_data[2:0];
					end
				end
				default: begin
					// A write beyond the register list has no effect.
				end
			endcase
		end
	end

	// After reset every row of valid and recency bits is zeroed, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_done_q <= 1'b0;
			clr_idx_q    <= '0;
		end else if (!clear_done_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == MAX_INDEX_BITS'(SETS - 1)) begin
				clear_done_q <= 1'b1;
			end
		end
	end

	// The set index is taken straight from the request so the row read can
	// start at the accept edge.
	assign off_in      = 6'(eb_q) + 6'(WORD_OFF);
	assign set_full_in = (s_axis_tdata >> off_in) & ~({ADDR_W{1'b1}} << ib_q);
	assign rd_set      = set_full_in[MAX_INDEX_BITS-1:0];

	// The tag row needs no clearing: a tag is only compared with its valid bit.
	salcl_ram #(
		.WIDTH(TROW_W),
		.DEPTH(SETS)
	) u_tag_ram (
		.clk  (clk),
		.we   (s1_fire),
		.waddr(set_s1),
		.wdata(tag_row_new),
		.re   (in_fire),
		.raddr(rd_set),
		.rdata(tag_rd)
	);

	assign meta_we    = !clear_done_q || s1_fire;
	assign meta_waddr = clear_done_q ? set_s1 : clr_idx_q;
	assign meta_wdata = clear_done_q ? meta_row_new : '0;

	salcl_ram #(
		.WIDTH(META_W),
		.DEPTH(SETS)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wdata),
		.re   (in_fire),
		.raddr(rd_set),
		.rdata(meta_rd)
	);

	// Lookup stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			byp_sel_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
				// The row read at this edge misses the write-back of the request
				// ahead when both hit the same set; the written row is kept instead.
				byp_sel_s1 <= s1_fire && (rd_set == set_s1);
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
				byp_sel_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_s1     <= s_axis_tdata;
			set_s1      <= rd_set;
			byp_tag_s1  <= tag_row_new;
			byp_meta_s1 <= meta_row_new;
		end
	end

	// Unpack the current set row, taking the bypass row when it is newer.
	always_comb begin
		logic [TROW_W-1:0] trow;
		logic [META_W-1:0] mrow;
		logic [5:0]        tag_shift;
		trow      = byp_sel_s1 ? byp_tag_s1 : tag_rd;
		mrow      = byp_sel_s1 ? byp_meta_s1 : meta_rd;
		tag_shift = 6'(eb_q) + 6'(WORD_OFF) + 6'(ib_q);
		tag_s1c   = TAG_W'(addr_s1 >> tag_shift);
		for (int w = 0; w < NUM_WAYS; w++) begin
			tags_cur[w]  = trow[w*TAG_W +: TAG_W];
			valid_cur[w] = mrow[w*(1+RANK_W) + RANK_W];
			rank_cur[w]  = mrow[w*(1+RANK_W) +: RANK_W];
		end
	end

	// Tag compare over the ways in use, target selection and recency update.
	always_comb begin
		logic [NUM_WAYS-1:0] in_use;
		logic                free;
		logic [WAY_IW-1:0]   hit_way;
		logic [WAY_IW-1:0]   free_way;
		logic [WAY_IW-1:0]   vic_way;
		logic [WAY_IW-1:0]   tgt;
		logic [RANK_W-1:0]   hit_rank;
		found    = 1'b0;
		free     = 1'b0;
		hit_way  = '0;
		free_way = '0;
		vic_way  = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			in_use[w] = (w < int'(ways_q));
		end
		// Lowest-numbered matching way, and lowest-numbered empty way.
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!found && in_use[w] && valid_cur[w] && (tags_cur[w] == tag_s1c)) begin
				found   = 1'b1;
				hit_way = WAY_IW'(w);
			end
			if (!free && in_use[w] && !valid_cur[w]) begin
				free     = 1'b1;
				free_way = WAY_IW'(w);
			end
		end
		// Oldest way; on equal ranks the lower number wins.
		for (int w = 1; w < NUM_WAYS; w++) begin
			if (in_use[w] && (rank_cur[w] > rank_cur[vic_way])) begin
				vic_way = WAY_IW'(w);
			end
		end
		if (found) begin
			tgt = hit_way;
		end else if (free) begin
			tgt = free_way;
		end else begin
			tgt = vic_way;
		end
		hit_rank = rank_cur[hit_way];
		for (int w = 0; w < NUM_WAYS; w++) begin
			tgt_oh[w]    = (tgt == WAY_IW'(w));
			tags_new[w]  = tags_cur[w];
			valid_new[w] = valid_cur[w];
			rank_new[w]  = rank_cur[w];
			if (tgt_oh[w]) begin
				// A fill writes the tag; a hit leaves it as it was.
				tags_new[w]  = found ? tags_cur[w] : tag_s1c;
				valid_new[w] = 1'b1;
				rank_new[w]  = '0;
			end else if (in_use[w] && valid_cur[w] && (!found || rank_cur[w] < hit_rank)
					&& (rank_cur[w] != RANK_MAX)) begin
				rank_new[w] = rank_cur[w] + 1'b1;
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			tag_row_new[w*TAG_W +: TAG_W]           = tags_new[w];
			meta_row_new[w*(1+RANK_W) + RANK_W]     = valid_new[w];
			meta_row_new[w*(1+RANK_W) +: RANK_W]    = rank_new[w];
		end
	end

	// Result register. The counters only move when a result is loaded, so
	// they double as the count fields of the result on display.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_cnt_q   <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else begin
			if (s1_fire) begin
				out_valid_q <= 1'b1;
				acc_cnt_q   <= acc_cnt_q + 1'b1;
				if (found) begin
					hit_cnt_q <= hit_cnt_q + 1'b1;
				end else begin
					miss_cnt_q <= miss_cnt_q + 1'b1;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_hit_q <= found;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
		miss_cnt_q, hit_cnt_q, acc_cnt_q, out_hit_q};

	// Every lookup touches exactly one way of its set.
	`SALCL_ASSERT_NOW(a_one_target_way, s1_fire, $onehot(tgt_oh))
	// Every access is counted as either a hit or a miss.
	`SALCL_ASSERT_NOW(a_counts_agree, out_valid_q, acc_cnt_q == hit_cnt_q + miss_cnt_q)
	// A completed lookup always shows up at the result register next cycle.
	`SALCL_ASSERT_NEXT(a_result_follows, s1_fire, out_valid_q)
	// The bypass row is only ever selected with a request in the lookup stage.
	`SALCL_ASSERT_NOW(a_bypass_has_item, byp_sel_s1, s1_valid_q)

endmodule

@@ src/salcl_ram.sv @@
module salcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
